@@ rtl/core/cpfw_pkg.sv @@
`default_nettype none
package cpfw_pkg;

  // field widths
  localparam int COORD_W   = 16;
  localparam int WIND_W    = 16;
  localparam int GRAD_W    = 32;
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int OFS_W      = COORD_W + 1;
  localparam int POS_W      = COORD_W + 2;
  localparam int MAG_W      = POS_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int R2_W       = SQ_W + 1;
  localparam int RAD_SQ_W   = 2 * COORD_W;
  localparam int BASE_W     = WIND_W + RAD_SQ_W;
  localparam int BASE_SPLIT = BASE_W / 2;
  localparam int R2_SPLIT   = (R2_W + 1) / 2;
  localparam int CM_W       = BASE_W + SQ_W;
  localparam int DSQ_W      = 2 * R2_W;
  localparam int WN_SHIFT   = 1;
  localparam int WD_SHIFT   = 2;
  localparam int WQ_SHIFT   = 10;
  localparam int NUM_W      = CM_W + WQ_SHIFT + 1;
  localparam int DEN_W      = DSQ_W + 1;
  localparam int QUO_W      = 42;
  localparam int DIV_STEPS  = QUO_W;
  localparam int TERM_W     = QUO_W - 1;
  localparam int CMP_W      = DEN_W + QUO_W - 1;
  localparam int WIDE_W     = 44;

  localparam int NUM_LANES  = 3;
  localparam int NUM_POINTS = 3;
  localparam int LANE_WN    = 0;
  localparam int LANE_WD    = 1;
  localparam int LANE_WQ    = 2;

  localparam logic signed [POS_W-1:0] GRAD_STEP = POS_W'(8);
  localparam logic [TERM_W-1:0] TERM_LIMIT = TERM_W'(1) << (TERM_W - 1);

  localparam logic signed [WIDE_W-1:0] WIND_MAX = WIDE_W'(32'sd32767);
  localparam logic signed [WIDE_W-1:0] WIND_MIN = WIDE_W'(-32'sd32768);
  localparam logic signed [WIDE_W-1:0] GRAD_MAX = WIDE_W'(33'sd2147483647);
  localparam logic signed [WIDE_W-1:0] GRAD_MIN = WIDE_W'(-33'sd2147483648);
  localparam logic signed [WIND_W-1:0] DOWNLIFT_LIMIT = WIND_W'(256);

  // register reset values
  localparam logic signed [COORD_W-1:0] RST_OBST_NORTH = COORD_W'(3680);
  localparam logic signed [COORD_W-1:0] RST_OBST_DOWN  = COORD_W'(0);
  localparam logic [COORD_W-1:0]        RST_RADIUS     = COORD_W'(640);
  localparam logic signed [WIND_W-1:0]  RST_WIND_SPEED = WIND_W'(-3072);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBST_NORTH = 3'd0,
    CFG_OBST_DOWN  = 3'd1,
    CFG_RADIUS     = 3'd2,
    CFG_WIND_SPEED = 3'd3,
    CFG_DOWNLIFT   = 3'd4
  } cfg_index_t;

  typedef logic [NUM_LANES-1:0][NUM_W-1:0]  num_set_t;
  typedef logic [NUM_LANES-1:0][QUO_W-1:0]  quo_set_t;
  typedef logic [NUM_LANES-1:0][TERM_W-1:0] term_set_t;

  typedef struct packed {
    logic diff_neg;
    logic xz_neg;
    logic singular;
  } point_flags_t;

  typedef struct packed {
    logic signed [WIND_W-1:0] wind_north;
    logic signed [WIND_W-1:0] wind_down;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     singular;
  } result_t;

  function automatic logic signed [WIND_W-1:0] sat_wind(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > WIND_MAX) ? WIND_MAX : ((v < WIND_MIN) ? WIND_MIN : v);
    return c[WIND_W-1:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > GRAD_MAX) ? GRAD_MAX : ((v < GRAD_MIN) ? GRAD_MIN : v);
    return c[GRAD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cpfw_front.sv @@
`default_nettype none
module cpfw_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [cpfw_pkg::POS_W-1:0]  px,
  input  logic signed [cpfw_pkg::POS_W-1:0]  pz,
  input  logic [cpfw_pkg::BASE_W-1:0]        base,
  output logic                               out_valid,
  output cpfw_pkg::num_set_t                 num,
  output logic [cpfw_pkg::DEN_W-1:0]         den,
  output cpfw_pkg::point_flags_t             flags
);
  import cpfw_pkg::*;

  logic [4:0] valid;

  // stage 1: magnitudes
  logic signed [POS_W-1:0] abs_x, abs_z;
  logic [MAG_W-1:0] ax, az;
  logic xz_neg1;

  // stage 2: squares and cross product
  logic [SQ_W-1:0] axx, azz, axz2;
  logic xz_neg2, sing2;

  // stage 3: radius squared and difference
  logic [R2_W-1:0] r2;
  logic [SQ_W-1:0] diffm, axz3;
  logic diff_neg3, xz_neg3, sing3;

  // stage 4: partial products
  logic [BASE_SPLIT+SQ_W-1:0] pp_d_lo, pp_d_hi, pp_x_lo, pp_x_hi;
  logic [R2_SPLIT+R2_W-1:0] pp_r_lo, pp_r_hi;
  point_flags_t flags4;

  // stage 5: full products
  logic [CM_W-1:0] cm_d, cm_x;
  logic [DSQ_W-1:0] dsq;
  point_flags_t flags5;

  assign abs_x = px[POS_W-1] ? -px : px;
  assign abs_z = pz[POS_W-1] ? -pz : pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid     <= {valid[3:0], in_valid};
      out_valid <= valid[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax      <= abs_x[MAG_W-1:0];
      az      <= abs_z[MAG_W-1:0];
      xz_neg1 <= px[POS_W-1] ^ pz[POS_W-1];

      axx     <= ax * ax;
      azz     <= az * az;
      axz2    <= ax * az;
      xz_neg2 <= xz_neg1;
      sing2   <= (ax == '0) && (az == '0);

      r2 <= R2_W'(axx) + R2_W'(azz);
      if (axx >= azz) begin
        diffm     <= axx - azz;
        diff_neg3 <= 1'b0;
      end else begin
        diffm     <= azz - axx;
        diff_neg3 <= 1'b1;
      end
      axz3    <= axz2;
      xz_neg3 <= xz_neg2;
      sing3   <= sing2;

      pp_d_lo <= base[BASE_SPLIT-1:0] * diffm;
      pp_d_hi <= base[BASE_W-1:BASE_SPLIT] * diffm;
      pp_x_lo <= base[BASE_SPLIT-1:0] * axz3;
      pp_x_hi <= base[BASE_W-1:BASE_SPLIT] * axz3;
      pp_r_lo <= r2[R2_SPLIT-1:0] * r2;
      pp_r_hi <= r2[R2_W-1:R2_SPLIT] * r2;
      flags4  <= '{diff_neg: diff_neg3, xz_neg: xz_neg3, singular: sing3};

      cm_d   <= CM_W'(pp_d_lo) + (CM_W'(pp_d_hi) << BASE_SPLIT);
      cm_x   <= CM_W'(pp_x_lo) + (CM_W'(pp_x_hi) << BASE_SPLIT);
      dsq    <= DSQ_W'(pp_r_lo) + (DSQ_W'(pp_r_hi) << R2_SPLIT);
      flags5 <= flags4;

      // rounding numerators: 2^k*c*m + d over 2*d
      num[LANE_WN] <= (NUM_W'(cm_d) << WN_SHIFT) + NUM_W'(dsq);
      num[LANE_WD] <= (NUM_W'(cm_x) << WD_SHIFT) + NUM_W'(dsq);
      num[LANE_WQ] <= (NUM_W'(cm_x) << WQ_SHIFT) + NUM_W'(dsq);
      den          <= {dsq, 1'b0};
      flags        <= flags5;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cpfw_divider.sv @@
`default_nettype none
module cpfw_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  cpfw_pkg::num_set_t          num,
  input  logic [cpfw_pkg::DEN_W-1:0]  den,
  input  cpfw_pkg::point_flags_t      flags_in,
  output logic                        out_valid,
  output cpfw_pkg::term_set_t         terms,
  output cpfw_pkg::point_flags_t      flags_out
);
  import cpfw_pkg::*;

  // one quotient bit per stage, most significant first
  logic         stg_valid [DIV_STEPS];
  num_set_t     stg_rem   [DIV_STEPS];
  quo_set_t     stg_quo   [DIV_STEPS];
  logic [DEN_W-1:0] stg_den [DIV_STEPS];
  point_flags_t stg_flags [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int K = DIV_STEPS - 1 - s;

    logic             cur_valid;
    num_set_t         cur_rem;
    quo_set_t         cur_quo;
    logic [DEN_W-1:0] cur_den;
    point_flags_t     cur_flags;
    logic [CMP_W-1:0] shifted_den;
    num_set_t         rem_next;
    quo_set_t         quo_next;

    if (s == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_rem   = num;
      assign cur_quo   = '0;
      assign cur_den   = den;
      assign cur_flags = flags_in;
    end else begin : g_next
      assign cur_valid = stg_valid[s-1];
      assign cur_rem   = stg_rem[s-1];
      assign cur_quo   = stg_quo[s-1];
      assign cur_den   = stg_den[s-1];
      assign cur_flags = stg_flags[s-1];
    end

    assign shifted_den = CMP_W'(cur_den) << K;

    // compare and subtract on each lane
    always_comb begin
      rem_next = cur_rem;
      quo_next = cur_quo;
      for (int l = 0; l < NUM_LANES; l++) begin
        if (CMP_W'(cur_rem[l]) >= shifted_den) begin
          rem_next[l]    = cur_rem[l] - shifted_den[NUM_W-1:0];
          quo_next[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s] <= 1'b0;
      end else if (en) begin
        stg_valid[s] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[s]   <= rem_next;
        stg_quo[s]   <= quo_next;
        stg_den[s]   <= cur_den;
        stg_flags[s] <= cur_flags;
      end
    end
  end

  // clamp the magnitude at the term limit
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (stg_quo[DIV_STEPS-1][l] > QUO_W'(TERM_LIMIT)) begin
        terms[l] = TERM_LIMIT;
      end else begin
        terms[l] = stg_quo[DIV_STEPS-1][l][TERM_W-1:0];
      end
    end
  end

  assign out_valid = stg_valid[DIV_STEPS-1];
  assign flags_out = stg_flags[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/core/cylinder_potential_flow_wind.sv @@
`default_nettype none
// Wind field of potential flow around a cylindrical obstacle.
// Input channel (in_valid/in_ready) takes one vehicle position word,
// north and down in 1/16 m. Output channel (out_valid/out_ready) gives one
// word per position: wind north and down (Q8.8 m/s), the two vertical-wind
// gradients and a flag for any evaluation point at the cylinder center.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// obstacle position, radius, free-stream speed and downlift clamp; it is
// always ready and must only be used while no word is in flight.
// One word is accepted every cycle while in_ready is high; the depth comes
// from the 42-step restoring dividers, one quotient bit per stage, with one
// three-lane divider per evaluation point.
// When the receiver stalls, the pipeline keeps moving until the output
// register is full and one more word sits in the skid register; then
// in_ready drops and the whole pipeline holds. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the default settings.
module cylinder_potential_flow_wind (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cpfw_pkg::COORD_W-1:0]   vehicle_north,
  input  logic signed [cpfw_pkg::COORD_W-1:0]   vehicle_down,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cpfw_pkg::WIND_W-1:0]    wind_north,
  output logic signed [cpfw_pkg::WIND_W-1:0]    wind_down,
  output logic signed [cpfw_pkg::GRAD_W-1:0]    gradient_along_x,
  output logic signed [cpfw_pkg::GRAD_W-1:0]    gradient_along_z,
  output logic                                  singular_point,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cpfw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpfw_pkg::COORD_W-1:0]          cfg_data
);
  import cpfw_pkg::*;

  // configuration registers
  logic signed [COORD_W-1:0] obstacle_north, obstacle_down;
  logic [COORD_W-1:0]        cyl_radius;
  logic signed [WIND_W-1:0]  stream_speed;
  logic                      prevent_downlift;

  logic [RAD_SQ_W-1:0] rsq;
  logic [BASE_W-1:0]   base;
  logic [WIND_W-1:0]   abs_speed;

  logic en;
  logic s1_valid;
  logic signed [OFS_W-1:0] x_ofs, z_ofs;
  logic signed [POS_W-1:0] px [NUM_POINTS];
  logic signed [POS_W-1:0] pz [NUM_POINTS];

  logic         fr_valid [NUM_POINTS];
  num_set_t     fr_num   [NUM_POINTS];
  logic [DEN_W-1:0] fr_den [NUM_POINTS];
  point_flags_t fr_flags [NUM_POINTS];

  logic         dv_valid [NUM_POINTS];
  term_set_t    dv_terms [NUM_POINTS];
  point_flags_t dv_flags [NUM_POINTS];

  // final combine stage
  logic signed [WIDE_W-1:0] v_wide, tw, td, wn_pre, wd_pre, wn_sing;
  logic signed [WIDE_W-1:0] wq_mag [NUM_POINTS];
  logic signed [WIDE_W-1:0] wq_val [NUM_POINTS];
  logic v_neg, wd_neg, sing_any, all_valid;

  logic c1_valid, c1_sing;
  logic signed [WIDE_W-1:0] c1_wn, c1_wd;
  logic signed [WIDE_W-1:0] c1_wq [NUM_POINTS];

  result_t res, out_word, skid_word;
  logic signed [WIND_W-1:0] wd_sat;
  logic skid_valid;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_north   <= RST_OBST_NORTH;
      obstacle_down    <= RST_OBST_DOWN;
      cyl_radius       <= RST_RADIUS;
      stream_speed     <= RST_WIND_SPEED;
      prevent_downlift <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_OBST_NORTH: obstacle_north   <= cfg_data;
        CFG_OBST_DOWN:  obstacle_down    <= cfg_data;
        CFG_RADIUS:     cyl_radius       <= cfg_data;
        CFG_WIND_SPEED: stream_speed     <= cfg_data;
        CFG_DOWNLIFT:   prevent_downlift <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // base = |V| * R^2, registered through rsq and then base
  assign abs_speed = stream_speed[WIND_W-1] ? WIND_W'(-stream_speed) : stream_speed;

  always_ff @(posedge clk) begin
    rsq  <= cyl_radius * cyl_radius;
    base <= abs_speed * rsq;
  end

  // pipeline advances unless the skid register is occupied
  assign en       = !skid_valid;
  assign in_ready = en && !rst;

  // offsets from the obstacle center
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_ofs <= OFS_W'(obstacle_north) - OFS_W'(vehicle_north);
      z_ofs <= OFS_W'(obstacle_down) - OFS_W'(vehicle_down);
    end
  end

  // center point and the two forward-difference points
  assign px[0] = POS_W'(x_ofs);
  assign pz[0] = POS_W'(z_ofs);
  assign px[1] = POS_W'(x_ofs) + GRAD_STEP;
  assign pz[1] = POS_W'(z_ofs);
  assign px[2] = POS_W'(x_ofs);
  assign pz[2] = POS_W'(z_ofs) - GRAD_STEP;

  for (genvar p = 0; p < NUM_POINTS; p++) begin : g_point
    cpfw_front u_front (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (s1_valid),
      .px        (px[p]),
      .pz        (pz[p]),
      .base      (base),
      .out_valid (fr_valid[p]),
      .num       (fr_num[p]),
      .den       (fr_den[p]),
      .flags     (fr_flags[p])
    );

    cpfw_divider u_divider (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (fr_valid[p]),
      .num       (fr_num[p]),
      .den       (fr_den[p]),
      .flags_in  (fr_flags[p]),
      .out_valid (dv_valid[p]),
      .terms     (dv_terms[p]),
      .flags_out (dv_flags[p])
    );
  end

  // apply signs and singular-point overrides
  always_comb begin
    v_wide  = WIDE_W'(stream_speed);
    v_neg   = stream_speed[WIND_W-1];
    wn_sing = v_neg ? WIND_MIN : ((stream_speed == '0) ? '0 : WIND_MAX);
    tw = WIDE_W'(dv_terms[0][LANE_WN]);
    td = WIDE_W'(dv_terms[0][LANE_WD]);
    if (v_neg != dv_flags[0].diff_neg) begin
      tw = -tw;
    end
    wd_neg = ~(v_neg ^ dv_flags[0].xz_neg);
    wn_pre = dv_flags[0].singular ? wn_sing : (v_wide - tw);
    wd_pre = dv_flags[0].singular ? '0 : (wd_neg ? -td : td);
    sing_any  = 1'b0;
    all_valid = 1'b1;
    for (int p = 0; p < NUM_POINTS; p++) begin
      wq_mag[p] = WIDE_W'(dv_terms[p][LANE_WQ]);
      if (dv_flags[p].singular) begin
        wq_val[p] = '0;
      end else if (~(v_neg ^ dv_flags[p].xz_neg)) begin
        wq_val[p] = -wq_mag[p];
      end else begin
        wq_val[p] = wq_mag[p];
      end
      sing_any  = sing_any | dv_flags[p].singular;
      all_valid = all_valid & dv_valid[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (en) begin
      c1_valid <= all_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_wn   <= wn_pre;
      c1_wd   <= wd_pre;
      c1_sing <= sing_any;
      for (int p = 0; p < NUM_POINTS; p++) begin
        c1_wq[p] <= wq_val[p];
      end
    end
  end

  // saturation, downlift clamp and gradients
  always_comb begin
    wd_sat = sat_wind(c1_wd);
    if (prevent_downlift && (wd_sat > DOWNLIFT_LIMIT)) begin
      wd_sat = DOWNLIFT_LIMIT;
    end
    res.wind_north = sat_wind(c1_wn);
    res.wind_down  = wd_sat;
    res.grad_x     = sat_grad((c1_wq[1] - c1_wq[0]) <<< 1);
    res.grad_z     = sat_grad((c1_wq[2] - c1_wq[0]) <<< 1);
    res.singular   = c1_sing;
  end

  // output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (c1_valid) begin
      if (!out_valid || out_ready) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign wind_north       = out_word.wind_north;
  assign wind_down        = out_word.wind_down;
  assign gradient_along_x = out_word.grad_x;
  assign gradient_along_z = out_word.grad_z;
  assign singular_point   = out_word.singular;

  // skid only holds a word behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word present without output word");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled while output was free");

  a_stalled_word_kept: assert property (@(posedge clk) disable iff (rst)
    (c1_valid && !skid_valid && out_valid && !out_ready) |=> skid_valid)
    else $error("word dropped during output stall");

endmodule
`default_nettype wire
